[src/substring_first_position_macros.svh]
// Assertion macros used by the port-level checker of the substring search block.
// Depends on nothing; every macro samples on i_clk and most are disabled during i_rst_n low.
`ifndef SUBSTRING_FIRST_POSITION_MACROS_SVH
`define SUBSTRING_FIRST_POSITION_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSFP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SSFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define SSFP_ASSERT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/ssfp_pkg.sv]
// Package of the substring search block: field widths, request kinds and shared types.
// Depends on nothing; every other file of the block but the macro header imports it.
package ssfp_pkg;

    localparam int CH_W      = 8;
    localparam int KIND_W    = 2;
    localparam int POS_W     = 11;
    localparam int RES_DEPTH = 4;
    localparam int RES_AW    = $clog2(RES_DEPTH);
    localparam int RES_CW    = $clog2(RES_DEPTH + 1);

    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;

    typedef logic [CH_W-1:0]  t_char;
    typedef logic [POS_W-1:0] t_pos;

    typedef enum logic [KIND_W-1:0] {
        KIND_PATTERN = 2'd0,
        KIND_SUBJECT = 2'd1,
        KIND_END     = 2'd2
    } t_kind;

    // Broadcast controls from the sequencer to every cell of the chain.
    typedef struct packed {
        logic shift;      // a subject character enters the window
        logic push;       // a pattern character enters the reversed pattern
        logic load_trim;  // the pushed character is not a space: refresh the aligned copy
    } t_cell_ctl;

endpackage

[src/ssfp_if.sv]
// Request and result channel interfaces of the substring search block.
// Depends on ssfp_pkg for the field widths.
interface ssfp_in_if import ssfp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    t_char             ch;

    modport source (output valid, kind, ch, input ready);
    modport sink (input valid, kind, ch, output ready);
endinterface

interface ssfp_out_if import ssfp_pkg::*; ();
    logic valid;
    logic ready;
    t_pos position;

    modport source (output valid, position, input ready);
    modport sink (input valid, position, output ready);
endinterface

[src/ssfp_cell.sv]
// One cell of the comparison chain: a window byte, a pattern byte and its aligned copy.
// Depends on ssfp_pkg; cells are chained by the top level, each but the first fed by its left neighbor.
module ssfp_cell import ssfp_pkg::*; #(
    parameter int K  = 0,
    parameter int TW = 8
) (
    input  logic          i_clk,
    input  t_cell_ctl     i_ctl,
    input  logic [TW-1:0] i_trim,
    input  t_char         i_subj_prev,
    input  t_char         i_pat_prev,
    output t_char         o_subj,
    output t_char         o_pat,
    output logic          o_hit
);

    t_char r_subj;
    t_char r_pat;
    t_char r_trim_pat;
    logic  r_hit;

    // Window and pattern bytes shift one cell on each shift or push control.
    // The aligned copy follows the full pattern only when a non-space arrives,
    // so it always holds the pattern without its trailing spaces.
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_subj <= i_subj_prev;
        end
        if (i_ctl.push) begin
            r_pat <= i_pat_prev;
        end
        if (i_ctl.load_trim) begin
            r_trim_pat <= i_pat_prev;
        end
        // Cells past the trimmed length always agree.
        r_hit <= (r_subj == r_trim_pat) || (i_trim <= TW'(K));
    end

    assign o_subj = r_subj;
    assign o_pat  = r_pat;
    assign o_hit  = r_hit;

endmodule

[src/ssfp_res_fifo.sv]
// Small result queue that decouples the search pipeline from the result channel.
// Depends on ssfp_pkg for the depth and the position type.
module ssfp_res_fifo import ssfp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_pos              i_data,
    input  logic              i_pop,
    output logic              o_valid,
    output t_pos              o_data,
    output logic [RES_CW-1:0] o_count
);

    t_pos              r_mem [RES_DEPTH];
    logic [RES_AW-1:0] r_head;
    logic [RES_AW-1:0] r_tail;
    logic [RES_CW-1:0] r_count;
    logic [RES_CW-1:0] n_count;

    // Occupancy follows push and pop; the writer never pushes into a full queue.
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + RES_CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - RES_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_tail <= r_tail + RES_AW'(1);
            end
            if (i_pop) begin
                r_head <= r_head + RES_AW'(1);
            end
            r_count <= n_count;
        end
    end

    // Entry storage carries no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_head];
    assign o_count = r_count;

endmodule

[src/substring_first_position.sv]
// Top level of the streaming first-occurrence substring search.
// Depends on ssfp_pkg, ssfp_if, ssfp_cell and ssfp_res_fifo.
//
// Usage: requests arrive on i_req (valid/ready). A request is a pattern character,
// a subject character or an end marker. Pattern characters build the pattern; the
// first one after reset or after an end marker starts a new pattern. Subject
// characters enter a window of PATTERN_MAX bytes held in a chain of cells, each
// comparing its window byte with the trimmed pattern byte aligned to it.
// An end marker yields one result on o_res: the 1-based start of the first match,
// or 0, modulo 2^11.
// Throughput: one request per cycle while i_req.ready is high. An end marker passes
// two pipeline flags, r_s1_end then r_s2_end, so the window check of the last subject
// character lands first; it is then written into the result queue, which drives o_res.
// Reset clears the counts, the pending match and the result queue; the next
// pattern character starts a new pattern.
// When the receiver stalls, up to four results wait in the queue; i_req.ready
// drops only while four results are queued or still on their way to the queue.
module substring_first_position import ssfp_pkg::*; #(
    parameter int PATTERN_MAX = 128,
    parameter int SUBJECT_MAX = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ssfp_in_if.sink     i_req,
    ssfp_out_if.source  o_res
);

    localparam int TW = $clog2(PATTERN_MAX + 1);
    localparam int CW = $clog2(SUBJECT_MAX + 1);
    localparam int LW = ((CW > TW) ? CW : TW) + 1;

    // Control state.
    logic [TW-1:0] r_pcount, n_pcount;
    logic [TW-1:0] r_trim, n_trim;
    logic          r_reload, n_reload;
    logic [CW-1:0] r_scount, n_scount;
    logic [CW-1:0] r_fm, n_fm;
    logic          r_s1_chk, n_s1_chk;
    logic          r_s1_end, n_s1_end;
    logic [CW-1:0] r_s1_pos, n_s1_pos;
    logic          r_s2_chk;
    logic          r_s2_end;
    logic [CW-1:0] r_s2_pos;

    logic          accept;
    logic          take_pat;
    logic          take_subj;
    logic          take_end;
    logic [TW-1:0] base_cnt;
    logic          nonspace;
    t_cell_ctl     cell_ctl;
    logic          all_hit;

    t_char                  subj_link [PATTERN_MAX];
    t_char                  pat_link  [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] hits;

    logic              res_pop;
    logic [RES_CW-1:0] res_count;

    // Request decode.
    assign accept = i_req.valid && i_req.ready;

    always_comb begin
        take_pat  = 1'b0;
        take_subj = 1'b0;
        take_end  = 1'b0;
        case (i_req.kind)
            KIND_PATTERN: take_pat  = accept;
            KIND_SUBJECT: take_subj = accept;
            KIND_END:     take_end  = accept;
            default:      ;
        endcase
    end

    // Pattern bookkeeping: reload, overflow and trailing-space trimming.
    assign base_cnt = r_reload ? '0 : r_pcount;
    assign nonspace = (i_req.ch != CH_SPACE);

    always_comb begin
        cell_ctl.push      = take_pat && (base_cnt < TW'(PATTERN_MAX));
        cell_ctl.load_trim = cell_ctl.push && nonspace;
        cell_ctl.shift     = take_subj && (r_scount < CW'(SUBJECT_MAX));

        n_pcount = r_pcount;
        n_trim   = r_trim;
        if (take_pat && r_reload) begin
            n_pcount = '0;
            n_trim   = '0;
        end
        if (cell_ctl.push) begin
            n_pcount = base_cnt + TW'(1);
        end
        if (cell_ctl.load_trim) begin
            n_trim = base_cnt + TW'(1);
        end

        n_reload = r_reload;
        if (take_end) begin
            n_reload = 1'b1;
        end else if (take_pat) begin
            n_reload = 1'b0;
        end
    end

    // Subject count and the first pipeline stage of the window check.
    always_comb begin
        n_scount = r_scount;
        if (take_end) begin
            n_scount = '0;
        end else if (cell_ctl.shift) begin
            n_scount = r_scount + CW'(1);
        end
        n_s1_chk = cell_ctl.shift && (r_trim != '0) &&
                   ((LW'(r_scount) + LW'(1)) >= LW'(r_trim));
        n_s1_pos = CW'(LW'(r_scount) + LW'(2) - LW'(r_trim));
        n_s1_end = take_end;
    end

    // The chain of cells.
    for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
        t_char subj_prev;
        t_char pat_prev;
        if (k == 0) begin : g_head
            assign subj_prev = i_req.ch;
            assign pat_prev  = i_req.ch;
        end else begin : g_body
            assign subj_prev = subj_link[k-1];
            assign pat_prev  = pat_link[k-1];
        end
        ssfp_cell #(
            .K  (k),
            .TW (TW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (cell_ctl),
            .i_trim      (r_trim),
            .i_subj_prev (subj_prev),
            .i_pat_prev  (pat_prev),
            .o_subj      (subj_link[k]),
            .o_pat       (pat_link[k]),
            .o_hit       (hits[k])
        );
    end

    // Second stage: the whole window agrees, keep the first match only.
    assign all_hit = &hits;

    always_comb begin
        n_fm = r_fm;
        if (r_s2_end) begin
            n_fm = '0;
        end else if (r_s2_chk && all_hit && (r_fm == '0)) begin
            n_fm = r_s2_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcount <= '0;
            r_trim   <= '0;
            r_reload <= 1'b1;
            r_scount <= '0;
            r_fm     <= '0;
            r_s1_chk <= 1'b0;
            r_s1_end <= 1'b0;
            r_s2_chk <= 1'b0;
            r_s2_end <= 1'b0;
        end else begin
            r_pcount <= n_pcount;
            r_trim   <= n_trim;
            r_reload <= n_reload;
            r_scount <= n_scount;
            r_fm     <= n_fm;
            r_s1_chk <= n_s1_chk;
            r_s1_end <= n_s1_end;
            r_s2_chk <= r_s1_chk;
            r_s2_end <= r_s1_end;
        end
    end

    // Match positions travel alongside the check flags.
    always_ff @(posedge i_clk) begin
        r_s1_pos <= n_s1_pos;
        r_s2_pos <= r_s1_pos;
    end

    // Result queue; ready reserves room for every end marker still in flight.
    assign res_pop     = o_res.valid && o_res.ready;
    assign i_req.ready = (res_count + RES_CW'(r_s1_end) + RES_CW'(r_s2_end))
                         < RES_CW'(RES_DEPTH);

    ssfp_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s2_end),
        .i_data  (POS_W'(r_fm)),
        .i_pop   (res_pop),
        .o_valid (o_res.valid),
        .o_data  (o_res.position),
        .o_count (res_count)
    );

endmodule

[src/ssfp_checker.sv]
// Port-level checker of the substring search block and its bind to the top level.
// Depends on ssfp_pkg and substring_first_position_macros.svh.
`include "substring_first_position_macros.svh"

module ssfp_checker import ssfp_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic [KIND_W-1:0] i_in_kind,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input t_pos              i_out_position
);

    logic end_acc;

    assign end_acc = i_in_valid && i_in_ready && (i_in_kind == KIND_END);

    // Reset leaves no result pending and the request side open.
    `SSFP_ASSERT_ALWAYS(a_reset_clean, !i_rst_n, i_in_ready && !i_out_valid, "state after reset")

    // Every end marker is followed by a valid result, stalled or not.
    `SSFP_ASSERT_NOW(a_end_latency, end_acc, ##3 i_out_valid, "end marker gave no result")

    // A result only appears because of an earlier end marker.
    `SSFP_ASSERT_NOW(a_result_cause, $rose(i_out_valid), $past(end_acc, 3), "result without request")

    // A stalled result stays put.
    `SSFP_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_position), "stalled result changed")

endmodule

bind substring_first_position ssfp_checker u_ssfp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_req.valid),
    .i_in_ready     (i_req.ready),
    .i_in_kind      (i_req.kind),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_out_position (o_res.position)
);
